[design/r2e_pkg.sv]
// Shared types, constants and the arctangent table for the rotation-to-Euler unit.
package r2e_pkg;

    localparam int LANE_W   = 20;
    localparam int Z_W      = 24;
    localparam int SQ_W     = 30;
    localparam int SQ_STEPS = 15;
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = 2;

    localparam logic signed [Z_W-1:0] PI_Q20      = 24'sd3294199;
    localparam logic signed [13:0]    HALF_PI_Q12 = 14'sd6434;
    localparam logic signed [14:0]    PI_Q12      = 15'sd12868;
    localparam logic signed [15:0]    ONE_Q14     = 16'sd16384;

    typedef enum logic [1:0] {
        SING_NONE = 2'd0,
        SING_POS  = 2'd1,
        SING_NEG  = 2'd2
    } sing_t;

    typedef struct packed {
        sing_t              sing;
        logic signed [15:0] p;
        logic [SQ_W-1:0]    v;
        logic signed [16:0] py;
        logic signed [16:0] px;
        logic signed [16:0] yy;
        logic signed [16:0] yx;
    } item_t;

    typedef struct packed {
        logic                     zero;
        logic signed [LANE_W-1:0] x;
        logic signed [LANE_W-1:0] y;
        logic signed [Z_W-1:0]    z;
    } lane_t;

    function automatic logic signed [Z_W-1:0] atan_q20(input int i);
        logic signed [Z_W-1:0] a;
        case (i)
            0:  a = 24'sd823550;
            1:  a = 24'sd486170;
            2:  a = 24'sd256879;
            3:  a = 24'sd130396;
            4:  a = 24'sd65451;
            5:  a = 24'sd32757;
            6:  a = 24'sd16383;
            7:  a = 24'sd8192;
            8:  a = 24'sd4096;
            9:  a = 24'sd2048;
            10: a = 24'sd1024;
            11: a = 24'sd512;
            12: a = 24'sd256;
            13: a = 24'sd128;
            14: a = 24'sd64;
            15: a = 24'sd32;
            16: a = 24'sd16;
            17: a = 24'sd8;
            18: a = 24'sd4;
            19: a = 24'sd2;
            20: a = 24'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic lane_t lane_init(input logic signed [LANE_W-1:0] y,
                                        input logic signed [LANE_W-1:0] x);
        lane_t l;
        l.zero = (x == '0) && (y == '0);
        l.x    = x;
        l.y    = y;
        l.z    = '0;
        if (x < 0)
        begin
            l.z = (y >= 0) ? PI_Q20 : -PI_Q20;
            l.x = -x;
            l.y = -y;
        end
        return l;
    endfunction

endpackage

[design/r2e_front.sv]
// Front end: configuration register, operand selection and singularity classification.
module r2e_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 push,
    output logic                 full,
    input  logic signed [15:0]   m00,
    input  logic signed [15:0]   m01,
    input  logic signed [15:0]   m02,
    input  logic signed [15:0]   m10,
    input  logic signed [15:0]   m11,
    input  logic signed [15:0]   m12,
    input  logic signed [15:0]   m20,
    input  logic signed [15:0]   m21,
    input  logic signed [15:0]   m22,
    output logic                 q_push,
    input  logic                 q_full,
    output r2e_pkg::item_t       q_item
);

    logic            axis_order_reg;
    logic            valid_reg;
    logic            valid_next;
    r2e_pkg::item_t  item_reg;
    r2e_pkg::item_t  item_next;
    logic            load;
    logic signed [31:0] psq;

    assign full   = valid_reg && q_full;
    assign load   = push && !full;
    assign q_push = valid_reg;
    assign q_item = item_reg;

    always_comb
    begin
        item_next = item_reg;
        if (!axis_order_reg)
        begin
            item_next.p  = m12;
            item_next.py = 17'(m02);
            item_next.px = 17'(m22);
            item_next.yy = 17'(m10);
            item_next.yx = 17'(m11);
            if (m12 >= r2e_pkg::ONE_Q14 || m12 <= -r2e_pkg::ONE_Q14)
            begin
                item_next.py = -17'(m01);
                item_next.px = 17'(m00);
            end
        end
        else
        begin
            item_next.p  = m01;
            item_next.py = 17'(m21);
            item_next.px = 17'(m11);
            item_next.yy = 17'(m02);
            item_next.yx = 17'(m00);
            if (m01 >= r2e_pkg::ONE_Q14 || m01 <= -r2e_pkg::ONE_Q14)
            begin
                item_next.py = -17'(m20);
                item_next.px = 17'(m22);
            end
        end
        psq = 32'(item_next.p) * 32'(item_next.p);
        if (item_next.p >= r2e_pkg::ONE_Q14)
        begin
            item_next.sing = r2e_pkg::SING_POS;
            item_next.v    = '0;
        end
        else if (item_next.p <= -r2e_pkg::ONE_Q14)
        begin
            item_next.sing = r2e_pkg::SING_NEG;
            item_next.v    = '0;
        end
        else
        begin
            item_next.sing = r2e_pkg::SING_NONE;
            item_next.v    = r2e_pkg::SQ_W'(32'sd268435456 - psq);
        end
    end

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (q_full)
            valid_next = valid_reg;
        else
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_order_reg <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                axis_order_reg <= cfg_wdata;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item_next;
    end

endmodule

[design/r2e_queue.sv]
// Short queue between the front end and the arithmetic back end.
module r2e_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  r2e_pkg::item_t  wr_item,
    input  logic            pop,
    output logic            empty,
    output r2e_pkg::item_t  rd_item
);

    r2e_pkg::item_t              mem [r2e_pkg::Q_DEPTH];
    logic [r2e_pkg::Q_AW-1:0]    wr_ptr_reg;
    logic [r2e_pkg::Q_AW-1:0]    rd_ptr_reg;
    logic [r2e_pkg::Q_AW:0]      count_reg;
    logic                        do_push;
    logic                        do_pop;

    assign full    = (count_reg == (r2e_pkg::Q_AW+1)'(r2e_pkg::Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_item;
    end

endmodule

[design/r2e_back.sv]
// Back end: pipelined integer square root, three CORDIC lanes and the result register.
module r2e_back
#(
    parameter int CORDIC_STEPS = 14
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  r2e_pkg::item_t      q_item,
    output logic                q_pop,
    output logic                empty,
    input  logic                pop,
    output logic signed [14:0]  pitch_angle,
    output logic signed [13:0]  roll_angle,
    output logic signed [14:0]  yaw_angle,
    output logic [1:0]          singular_case
);

    typedef struct packed {
        r2e_pkg::item_t            item;
        logic [r2e_pkg::SQ_W-1:0]  v;
        logic [r2e_pkg::SQ_W-1:0]  res;
    } sq_t;

    typedef struct packed {
        r2e_pkg::lane_t [2:0] lanes;
        r2e_pkg::sing_t       sing;
    } ck_t;

    localparam int NSQ = r2e_pkg::SQ_STEPS;

    logic  en;
    sq_t   sq_reg   [NSQ];
    logic  sqv_reg  [NSQ];
    ck_t   ck_reg   [CORDIC_STEPS+1];
    logic  ckv_reg  [CORDIC_STEPS+1];
    logic  out_valid_reg;
    logic signed [14:0] pitch_reg;
    logic signed [14:0] pitch_next;
    logic signed [13:0] roll_reg;
    logic signed [13:0] roll_next;
    logic signed [14:0] yaw_reg;
    logic signed [14:0] yaw_next;
    logic [1:0]         sing_reg;

    assign en            = !out_valid_reg || pop;
    assign q_pop         = en && !q_empty;
    assign empty         = !out_valid_reg;
    assign pitch_angle   = pitch_reg;
    assign roll_angle    = roll_reg;
    assign yaw_angle     = yaw_reg;
    assign singular_case = sing_reg;

    function automatic r2e_pkg::lane_t cordic_step(input r2e_pkg::lane_t l, input int i);
        r2e_pkg::lane_t o;
        logic signed [r2e_pkg::LANE_W-1:0] xs;
        logic signed [r2e_pkg::LANE_W-1:0] ys;
        xs = l.x >>> i;
        ys = l.y >>> i;
        o  = l;
        if (l.y >= 0)
        begin
            o.x = l.x + ys;
            o.y = l.y - xs;
            o.z = l.z + r2e_pkg::atan_q20(i);
        end
        else
        begin
            o.x = l.x - ys;
            o.y = l.y + xs;
            o.z = l.z - r2e_pkg::atan_q20(i);
        end
        return o;
    endfunction

    function automatic logic signed [16:0] round_q12(input r2e_pkg::lane_t l);
        logic signed [r2e_pkg::Z_W:0] t;
        t = (r2e_pkg::Z_W+1)'(l.z) + 25'sd128;
        return l.zero ? 17'sd0 : 17'(t >>> 8);
    endfunction

    for (genvar k = 0; k < NSQ; k++)
    begin : g_sq
        sq_t  src;
        logic src_v;
        sq_t  nxt;
        logic [r2e_pkg::SQ_W-1:0] bitv;
        logic [r2e_pkg::SQ_W-1:0] sum;

        assign bitv = r2e_pkg::SQ_W'(1) << (2 * (NSQ - 1 - k));

        if (k == 0)
        begin : g_first
            always_comb
            begin
                src.item = q_item;
                src.v    = q_item.v;
                src.res  = '0;
                src_v    = q_pop;
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                src   = sq_reg[k-1];
                src_v = sqv_reg[k-1];
            end
        end

        always_comb
        begin
            nxt = src;
            sum = src.res + bitv;
            if (src.v >= sum)
            begin
                nxt.v   = src.v - sum;
                nxt.res = (src.res >> 1) + bitv;
            end
            else
            begin
                nxt.res = src.res >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sqv_reg[k] <= 1'b0;
            else if (en)
                sqv_reg[k] <= src_v;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                sq_reg[k] <= nxt;
        end
    end

    ck_t   pre_next;
    sq_t   sq_last;

    assign sq_last = sq_reg[NSQ-1];

    always_comb
    begin
        pre_next.sing     = sq_last.item.sing;
        pre_next.lanes[0] = r2e_pkg::lane_init(r2e_pkg::LANE_W'(sq_last.item.p),
                                               r2e_pkg::LANE_W'(sq_last.res));
        pre_next.lanes[1] = r2e_pkg::lane_init(r2e_pkg::LANE_W'(sq_last.item.py),
                                               r2e_pkg::LANE_W'(sq_last.item.px));
        pre_next.lanes[2] = r2e_pkg::lane_init(r2e_pkg::LANE_W'(sq_last.item.yy),
                                               r2e_pkg::LANE_W'(sq_last.item.yx));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ckv_reg[0] <= 1'b0;
        else if (en)
            ckv_reg[0] <= sqv_reg[NSQ-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            ck_reg[0] <= pre_next;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_ck
        ck_t nxt;

        always_comb
        begin
            nxt = ck_reg[i];
            for (int l = 0; l < 3; l++)
                nxt.lanes[l] = cordic_step(ck_reg[i].lanes[l], i);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ckv_reg[i+1] <= 1'b0;
            else if (en)
                ckv_reg[i+1] <= ckv_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                ck_reg[i+1] <= nxt;
        end
    end

    ck_t                last;
    logic signed [16:0] roll_r;
    logic signed [16:0] pitch_r;
    logic signed [16:0] yaw_r;

    assign last = ck_reg[CORDIC_STEPS];

    always_comb
    begin
        roll_r  = round_q12(last.lanes[0]);
        pitch_r = round_q12(last.lanes[1]);
        yaw_r   = round_q12(last.lanes[2]);
        if (last.sing == r2e_pkg::SING_NEG)
            pitch_r = -pitch_r;

        if (pitch_r > 17'(r2e_pkg::PI_Q12))
            pitch_next = r2e_pkg::PI_Q12;
        else if (pitch_r < -17'(r2e_pkg::PI_Q12))
            pitch_next = -r2e_pkg::PI_Q12;
        else
            pitch_next = 15'(pitch_r);

        if (yaw_r > 17'(r2e_pkg::PI_Q12))
            yaw_next = r2e_pkg::PI_Q12;
        else if (yaw_r < -17'(r2e_pkg::PI_Q12))
            yaw_next = -r2e_pkg::PI_Q12;
        else
            yaw_next = 15'(yaw_r);

        if (roll_r > 17'(r2e_pkg::HALF_PI_Q12))
            roll_next = r2e_pkg::HALF_PI_Q12;
        else if (roll_r < -17'(r2e_pkg::HALF_PI_Q12))
            roll_next = -r2e_pkg::HALF_PI_Q12;
        else
            roll_next = 14'(roll_r);

        case (last.sing)
            r2e_pkg::SING_POS:
            begin
                roll_next = r2e_pkg::HALF_PI_Q12;
                yaw_next  = '0;
            end
            r2e_pkg::SING_NEG:
            begin
                roll_next = -r2e_pkg::HALF_PI_Q12;
                yaw_next  = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= ckv_reg[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pitch_reg <= pitch_next;
            roll_reg  <= roll_next;
            yaw_reg   <= yaw_next;
            sing_reg  <= last.sing;
        end
    end

endmodule

[design/rotation_to_euler_angles_unit.sv]
// Top level of the rotation matrix to Euler angles unit.
//
//  channel   handshake          payload
//  config    cfg_we             cfg_wdata (axis_order)
//  matrix    push / full        m00 .. m22
//  angles    pop / empty        pitch_angle roll_angle yaw_angle singular_case
//
//  One transaction per cycle sustained while each result is popped as soon as it is presented.
//  The depth is set by the 15-stage square root and the CORDIC_STEPS rotation stages.
//  Reset clears the axis order to YXZ and empties every stage and queue.
//  A held result stalls the back end; the four-entry queue keeps the front end accepting until it fills.
module rotation_to_euler_angles_unit
#(
    parameter int CORDIC_STEPS = 14
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                push,
    output logic                full,
    input  logic signed [15:0]  m00,
    input  logic signed [15:0]  m01,
    input  logic signed [15:0]  m02,
    input  logic signed [15:0]  m10,
    input  logic signed [15:0]  m11,
    input  logic signed [15:0]  m12,
    input  logic signed [15:0]  m20,
    input  logic signed [15:0]  m21,
    input  logic signed [15:0]  m22,
    output logic                empty,
    input  logic                pop,
    output logic signed [14:0]  pitch_angle,
    output logic signed [13:0]  roll_angle,
    output logic signed [14:0]  yaw_angle,
    output logic [1:0]          singular_case
);

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    r2e_pkg::item_t  f_item;
    r2e_pkg::item_t  b_item;

    r2e_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .full      (full),
        .m00       (m00),
        .m01       (m01),
        .m02       (m02),
        .m10       (m10),
        .m11       (m11),
        .m12       (m12),
        .m20       (m20),
        .m21       (m21),
        .m22       (m22),
        .q_push    (q_push),
        .q_full    (q_full),
        .q_item    (f_item)
    );

    r2e_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .full    (q_full),
        .wr_item (f_item),
        .pop     (q_pop),
        .empty   (q_empty),
        .rd_item (b_item)
    );

    r2e_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_item        (b_item),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .pitch_angle   (pitch_angle),
        .roll_angle    (roll_angle),
        .yaw_angle     (yaw_angle),
        .singular_case (singular_case)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> singular_case != 2'd3)
        else $error("invalid singular code");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && singular_case != 2'(r2e_pkg::SING_NONE)) |-> yaw_angle == 15'sd0)
        else $error("yaw not zero in singular case");

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (roll_angle <= r2e_pkg::HALF_PI_Q12 && roll_angle >= -r2e_pkg::HALF_PI_Q12))
        else $error("roll out of range");

endmodule
